// ===== design/bfifo_pkg.sv =====
// shared types and codes for the byte ring fifo
// payload structs, action and status codes, controller/datapath links
// no dependencies
package bfifo_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int PEEK_MAX_DEF = 64;

  localparam logic [2:0] ACT_WRITE   = 3'd0;
  localparam logic [2:0] ACT_READ    = 3'd1;
  localparam logic [2:0] ACT_PEEK    = 3'd2;
  localparam logic [2:0] ACT_CONSUME = 3'd3;
  localparam logic [2:0] ACT_FLUSH   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_in;
    logic [7:0] amount_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [7:0] amount_out;
    logic       last;
    logic       is_empty;
    logic       is_full;
    logic [7:0] fill_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic imm;       // finish the accepted word without a store read
    logic start;     // start a store read sequence (read or peek)
    logic mem_load;  // move store read data into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_op;    // accepted word needs a store read
    logic mem_last;  // current store result is the final one
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

// ===== design/byte_ring_fifo_peek_consume.sv =====
// top level of the byte ring fifo with peek and consume
// depends on bfifo_pkg, bfifo_ctrl, bfifo_dp (which holds bfifo_ram)

// Byte FIFO in a circular store of DEPTH bytes that keeps one slot free, so
// at most DEPTH-1 bytes are held. Each input word carries one action: write,
// read, peek (up to min(amount_in, PEEK_MAX, fill level) oldest bytes, one
// result word each, last on the final one, read side untouched), consume
// (drop up to amount_in bytes) or flush (both pointers to zero). Every result
// word reports status, fill level, empty and full after the step. Write,
// consume, flush and the unused codes need no store read; a read or a peek
// goes through the registered read port of the byte store, after which
// peeked bytes come out one per cycle while the output register is free.
// Results sit in an output register; the next input word is taken in the
// same cycle the last result of the previous one leaves it.
// The store needs no clearing after reset, so the block is ready at once.
module byte_ring_fifo_peek_consume #(
  parameter int DEPTH    = bfifo_pkg::DEPTH_DEF,
  parameter int PEEK_MAX = bfifo_pkg::PEEK_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfifo_pkg::in_item_t  in_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfifo_pkg::out_item_t out_data
);

  // command and status between sequencer and datapath
  bfifo_pkg::ctrl_cmd_t  cmd;
  bfifo_pkg::dp_status_t sts;

  // sequencer: actions without a store read or a run of store reads
  bfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pointers, occupancy, byte store and output register
  bfifo_dp #(
    .DEPTH    (DEPTH),
    .PEEK_MAX (PEEK_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/bfifo_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module bfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/bfifo_ctrl.sv =====
// sequencing controller for the byte ring fifo
// depends on bfifo_pkg (command and status structs)
module bfifo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bfifo_pkg::dp_status_t sts,
  output bfifo_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_MEM
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (sts.mem_op) begin
            cmd.start = 1'b1;
            state_nxt = S_MEM;
          end else begin
            cmd.imm = 1'b1;
          end
        end
      end
      S_MEM: begin
        if (sts.out_free) begin
          cmd.mem_load = 1'b1;
          if (sts.mem_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_enters_mem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_MEM))
    else $error("store sequence started but controller not in memory state");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_load && sts.mem_last) |=> (state_r == S_IDLE))
    else $error("final store word loaded but controller still busy");
`endif

endmodule

// ===== design/bfifo_dp.sv =====
// datapath of the byte ring fifo: pointers, fill count, store, output register
// depends on bfifo_pkg and bfifo_ram
module bfifo_dp #(
  parameter int DEPTH    = bfifo_pkg::DEPTH_DEF,
  parameter int PEEK_MAX = bfifo_pkg::PEEK_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfifo_pkg::in_item_t   in_data,
  input  bfifo_pkg::ctrl_cmd_t  cmd,
  output bfifo_pkg::dp_status_t sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfifo_pkg::out_item_t  out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = (PW > 8) ? PW : 8;
  localparam int NW = $clog2(PEEK_MAX + 1);
  localparam logic [PW:0]   DEPTH_W    = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] FULL_CNT   = PW'(DEPTH - 1);
  localparam logic [CW-1:0] PEEK_MAX_W = CW'(PEEK_MAX);

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                            input logic [PW-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] fill(input logic [PW-1:0] wp,
                                         input logic [PW-1:0] rp);
    logic [PW:0] d;
    if (wp >= rp) begin
      d = {1'b0, wp} - {1'b0, rp};
    end else begin
      d = {1'b0, wp} + DEPTH_W - {1'b0, rp};
    end
    return d[PW-1:0];
  endfunction

  function automatic bfifo_pkg::out_item_t mk_out(input logic [1:0]    st,
                                                  input logic [7:0]    dat,
                                                  input logic [7:0]    amt,
                                                  input logic          lst,
                                                  input logic [PW-1:0] cnt);
    bfifo_pkg::out_item_t o;
    logic [CW-1:0]        c;
    c            = CW'(cnt);
    o.status     = st;
    o.data_out   = dat;
    o.amount_out = amt;
    o.last       = lst;
    o.is_empty   = (cnt == '0);
    o.is_full    = (cnt == FULL_CNT);
    o.fill_level = c[7:0];
    return o;
  endfunction

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] raddr_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] idx_r;
  logic          is_read_r;
  logic          out_valid_r, out_valid_nxt;
  bfifo_pkg::out_item_t out_r, out_nxt;

  logic [PW-1:0] cnt_cur;
  logic          now_empty;
  logic [CW-1:0] cnt_ext, amt_ext, cons_n, pk_lim, pk_n_w;
  logic [NW-1:0] pk_n;
  logic [PW-1:0] wp_imm, rp_imm;
  logic [1:0]    st_imm;
  logic [7:0]    amt_imm;
  logic          wr_en;
  bfifo_pkg::out_item_t imm_out, mem_out;

  logic          mem_last;
  logic [PW-1:0] rp_adv, raddr_adv;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // current occupancy and length limits
  assign cnt_cur   = fill(wp_r, rp_r);
  assign now_empty = (cnt_cur == '0);
  assign cnt_ext   = CW'(cnt_cur);
  assign amt_ext   = CW'(in_data.amount_in);
  assign cons_n    = (amt_ext < cnt_ext) ? amt_ext : cnt_ext;
  assign pk_lim    = (amt_ext < PEEK_MAX_W) ? amt_ext : PEEK_MAX_W;
  assign pk_n_w    = (pk_lim < cnt_ext) ? pk_lim : cnt_ext;
  assign pk_n      = pk_n_w[NW-1:0];

  // actions that need no store read
  always_comb begin
    wp_imm  = wp_r;
    rp_imm  = rp_r;
    st_imm  = bfifo_pkg::ST_OK;
    amt_imm = 8'd0;
    wr_en   = 1'b0;
    unique case (in_data.action) inside
      bfifo_pkg::ACT_WRITE: begin
        if (cnt_cur == FULL_CNT) begin
          st_imm = bfifo_pkg::ST_FULL;
        end else begin
          wr_en  = cmd.imm;
          wp_imm = ptr_add(wp_r, PW'(1));
        end
      end
      bfifo_pkg::ACT_READ, bfifo_pkg::ACT_PEEK: begin
        if (now_empty) begin
          st_imm = bfifo_pkg::ST_EMPTY;
        end
      end
      bfifo_pkg::ACT_CONSUME: begin
        if (now_empty) begin
          st_imm = bfifo_pkg::ST_EMPTY;
        end else begin
          rp_imm  = ptr_add(rp_r, cons_n[PW-1:0]);
          amt_imm = cons_n[7:0];
        end
      end
      bfifo_pkg::ACT_FLUSH: begin
        wp_imm = '0;
        rp_imm = '0;
      end
      default: begin
        wp_imm = wp_r;
      end
    endcase
  end

  assign imm_out = mk_out(st_imm, 8'd0, amt_imm, 1'b1, fill(wp_imm, rp_imm));

  // store read sequence
  assign mem_last  = ((idx_r + NW'(1)) == n_r);
  assign rp_adv    = ptr_add(rp_r, PW'(1));
  assign raddr_adv = ptr_add(raddr_r, PW'(1));
  assign rd_en     = cmd.start || (cmd.mem_load && !mem_last);
  assign rd_addr   = cmd.start ? rp_r : raddr_adv;
  assign mem_out   = mk_out(bfifo_pkg::ST_OK, rd_data,
                            is_read_r ? 8'd0 : 8'(n_r), mem_last,
                            fill(wp_r, is_read_r ? rp_adv : rp_r));

  assign sts.mem_op   = ((in_data.action == bfifo_pkg::ACT_READ) && !now_empty) ||
                        ((in_data.action == bfifo_pkg::ACT_PEEK) && (pk_n != '0));
  assign sts.mem_last = mem_last;
  assign sts.out_free = !out_valid_r || out_ready;

  bfifo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_data.data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wp_nxt = cmd.imm ? wp_imm : wp_r;
    if (cmd.imm) begin
      rp_nxt = rp_imm;
    end else if (cmd.mem_load && is_read_r) begin
      rp_nxt = rp_adv;
    end else begin
      rp_nxt = rp_r;
    end
    if (cmd.imm) begin
      out_nxt = imm_out;
    end else if (cmd.mem_load) begin
      out_nxt = mem_out;
    end else begin
      out_nxt = out_r;
    end
    if (cmd.imm || cmd.mem_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.start) begin
      is_read_r <= (in_data.action == bfifo_pkg::ACT_READ);
      n_r       <= (in_data.action == bfifo_pkg::ACT_READ) ? NW'(1) : pk_n;
      idx_r     <= '0;
      raddr_r   <= rp_r;
    end else if (cmd.mem_load && !mem_last) begin
      idx_r   <= idx_r + NW'(1);
      raddr_r <= raddr_adv;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wp_r} < DEPTH_W) && ({1'b0, rp_r} < DEPTH_W))
    else $error("fifo pointer outside the store");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.imm || cmd.mem_load) |-> sts.out_free)
    else $error("output register overwritten while still held");

  a_peek_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_load |-> ((n_r != '0) && (idx_r < n_r)))
    else $error("store sequence index beyond its length");
`endif

endmodule
